[src/bsd_pkg.sv]
// Shared types and constants for the BMP stream decoder.
// Used by every module of the block; depends on nothing else.
package bsd_pkg;

   localparam int unsigned MaxDim      = 4096;
   localparam int unsigned PaletteSize = 256;
   localparam logic [15:0] BmSignature = 16'h4d42;
   localparam logic [31:0] InfoHdrSize = 32'd40;
   localparam logic [31:0] CoreHdrSize = 32'd12;

   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_SIGNATURE = 3'd1;
   localparam logic [2:0] ERR_HEADER    = 3'd2;
   localparam logic [2:0] ERR_DEPTH     = 3'd3;
   localparam logic [2:0] ERR_COMPRESS  = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } bsd_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [2:0]  error_code;
      logic [12:0] image_width;
      logic [12:0] image_height;
   } bsd_rsp_type;

   // Result qualifiers from the parser to the output register.
   typedef struct packed {
      logic valid;
      logic use_pal;
   } bsd_ctl_type;

   typedef struct packed {
      logic        we;
      logic [7:0]  addr;
      logic [23:0] data;
   } bsd_pal_wr_type;

endpackage

[src/bmp_stream_decoder.sv]
// Top level of the BMP stream decoder: parser, palette store and result register.
// Depends on bsd_pkg, bsd_parser and bsd_palette.
//
// The decoder takes one file byte per word and can accept a word in every cycle; each
// pixel, error or done word appears in the cycle after the byte that causes it. Results
// sit in a single output register; the input is stalled only while that register is
// full and the result side stalls. For 8-bit images the colour comes from a 256-entry
// palette memory read in the same cycle the index byte is taken. After a done or error
// word the decoder ignores further input until reset.
module bmp_stream_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bsd_pkg::bsd_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bsd_pkg::bsd_rsp_type rsp_word
);
   import bsd_pkg::*;

   logic           fire;
   bsd_rsp_type    res;
   bsd_ctl_type    ctl;
   bsd_pal_wr_type pal_wr;
   logic [23:0]    pal_rd;

   logic           rsp_valid_ff;
   logic           use_pal_ff;
   bsd_rsp_type    rsp_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign fire      = req_valid & ~req_stall;

   bsd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .req    (req_word),
      .res    (res),
      .ctl    (ctl),
      .pal_wr (pal_wr)
   );

   bsd_palette u_palette (
      .clock   (clock),
      .wr      (pal_wr),
      .rd_en   (fire),
      .rd_addr (req_word.data_byte),
      .rd_data (pal_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= ctl.valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff     <= res;
         use_pal_ff <= ctl.use_pal;
      end
   end

   always_comb begin
      rsp_word = rsp_ff;
      if (use_pal_ff) begin
         rsp_word.red   = pal_rd[23:16];
         rsp_word.green = pal_rd[15:8];
         rsp_word.blue  = pal_rd[7:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/bsd_palette.sv]
// Palette store of the BMP stream decoder: 256 colours with a registered read port.
// Depends on bsd_pkg.
module bsd_palette (
   input  logic                   clock,
   input  bsd_pkg::bsd_pal_wr_type wr,
   input  logic                   rd_en,
   input  logic [7:0]             rd_addr,
   output logic [23:0]            rd_data
);
   import bsd_pkg::*;

   logic [23:0] mem [PaletteSize];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bsd_parser.sv]
// Header, palette and pixel sequencing for the BMP stream decoder.
// Depends on bsd_pkg; drives the palette write port and at most one result per word.
module bsd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  bsd_pkg::bsd_req_type    req,
   output bsd_pkg::bsd_rsp_type    res,
   output bsd_pkg::bsd_ctl_type    ctl,
   output bsd_pkg::bsd_pal_wr_type pal_wr
);
   import bsd_pkg::*;

   typedef enum logic [5:0] {
      PH_HEADER  = 6'b000001,
      PH_PALETTE = 6'b000010,
      PH_PIXELS  = 6'b000100,
      PH_PAD     = 6'b001000,
      PH_DONE    = 6'b010000,
      PH_HALT    = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  bc_ff, bc_in;
   logic [31:0] acc_ff, acc_in;
   logic        core_ff, core_in;
   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [4:0]  depth_ff, depth_in;
   logic [8:0]  colours_ff, colours_in;
   logic [8:0]  pidx_ff, pidx_in;
   logic [1:0]  ppos_ff, ppos_in;
   logic [11:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   logic [1:0]  pad_ff, pad_in;

   logic [31:0] acc_shift;
   logic [15:0] acc_hi;
   logic [2:0]  err;
   logic        start_pix;
   logic        end_hdr;
   logic [8:0]  hdr_colours;
   logic        pix_out;
   logic [23:0] pix_rgb;
   logic [12:0] col_next;
   logic [12:0] row_next;
   logic [1:0]  pad_calc;
   logic [12:0] y_full;
   logic        depth8;

   assign acc_shift = {req.data_byte, acc_ff[31:8]};
   assign acc_hi    = acc_shift[31:16];
   assign depth8    = (depth_ff == 5'd8);
   assign col_next  = {1'b0, col_ff} + 13'd1;
   assign row_next  = row_ff + 13'd1;
   assign y_full    = height_ff - 13'd1 - row_ff;
   // Bytes per row modulo four, then the padding that brings it to a multiple of four.
   assign pad_calc  = 2'd0 - (depth8 ? width_ff[1:0] : 2'(width_ff[1:0] * 2'd3));

   always_comb begin
      phase_in   = phase_ff;
      bc_in      = bc_ff;
      acc_in     = acc_ff;
      core_in    = core_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      depth_in   = depth_ff;
      colours_in = colours_ff;
      pidx_in    = pidx_ff;
      ppos_in    = ppos_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pad_in     = pad_ff;
      err        = ERR_NONE;
      start_pix  = 1'b0;
      end_hdr    = 1'b0;
      hdr_colours = 9'd0;
      pix_out    = 1'b0;
      pix_rgb    = 24'd0;
      res        = '0;
      ctl        = '0;
      pal_wr     = '0;
      pal_wr.addr = pidx_ff[7:0];
      pal_wr.data = acc_shift[31:8];

      if (fire) begin
         case (phase_ff)
            PH_HALT: begin
            end
            PH_DONE: begin
               phase_in  = PH_HALT;
               ctl.valid = 1'b1;
               res.kind  = KIND_DONE;
            end
            default: begin
               if (req.end_of_stream) begin
                  err = ERR_TRUNCATED;
               end else begin
                  case (phase_ff)
                     PH_HEADER: begin
                        acc_in = acc_shift;
                        bc_in  = bc_ff + 6'd1;
                        if (bc_ff == 6'd1) begin
                           if (acc_hi != BmSignature) err = ERR_SIGNATURE;
                        end else if (bc_ff == 6'd17) begin
                           if (acc_shift == InfoHdrSize) core_in = 1'b0;
                           else if (acc_shift == CoreHdrSize) core_in = 1'b1;
                           else err = ERR_HEADER;
                        end else if (!core_ff) begin
                           case (bc_ff)
                              6'd21: begin
                                 if (acc_shift > 32'(MaxDim)) err = ERR_HEADER;
                                 else width_in = acc_shift[12:0];
                              end
                              6'd25: begin
                                 if (acc_shift > 32'(MaxDim)) err = ERR_HEADER;
                                 else height_in = acc_shift[12:0];
                              end
                              6'd29: begin
                                 depth_in = (acc_hi < 16'd32) ? acc_hi[4:0] : 5'd31;
                                 if (!(acc_hi == 16'd8 || acc_hi == 16'd24)) err = ERR_DEPTH;
                              end
                              6'd33: begin
                                 if (acc_shift != 32'd0) err = ERR_COMPRESS;
                              end
                              6'd49: begin
                                 if (acc_shift > 32'(PaletteSize)) begin
                                    err = ERR_HEADER;
                                 end else if (acc_shift == 32'd0) begin
                                    colours_in = depth8 ? 9'(PaletteSize) : 9'd0;
                                 end else begin
                                    colours_in = acc_shift[8:0];
                                 end
                              end
                              6'd53: begin
                                 end_hdr     = 1'b1;
                                 hdr_colours = colours_ff;
                              end
                              default: begin
                              end
                           endcase
                        end else begin
                           case (bc_ff)
                              6'd19: begin
                                 if (acc_hi > 16'(MaxDim)) err = ERR_HEADER;
                                 else width_in = acc_hi[12:0];
                              end
                              6'd21: begin
                                 if (acc_hi > 16'(MaxDim)) err = ERR_HEADER;
                                 else height_in = acc_hi[12:0];
                              end
                              6'd25: begin
                                 depth_in = (acc_hi < 16'd32) ? acc_hi[4:0] : 5'd31;
                                 if (!(acc_hi == 16'd8 || acc_hi == 16'd24)) begin
                                    err = ERR_DEPTH;
                                 end else begin
                                    // The core header carries no used-colour count.
                                    hdr_colours = (acc_hi == 16'd8) ? 9'(PaletteSize) : 9'd0;
                                    colours_in  = hdr_colours;
                                    end_hdr     = 1'b1;
                                 end
                              end
                              default: begin
                              end
                           endcase
                        end
                        if (end_hdr) begin
                           if (hdr_colours != 9'd0) begin
                              pidx_in  = 9'd0;
                              ppos_in  = 2'd0;
                              phase_in = PH_PALETTE;
                           end else begin
                              start_pix = 1'b1;
                           end
                        end
                     end
                     PH_PALETTE: begin
                        acc_in = acc_shift;
                        // Entries arrive blue, green, red; the third byte completes one.
                        pal_wr.we = (ppos_ff == 2'd2);
                        if (ppos_ff == (core_ff ? 2'd2 : 2'd3)) begin
                           ppos_in = 2'd0;
                           pidx_in = pidx_ff + 9'd1;
                           if (pidx_ff + 9'd1 == colours_ff) start_pix = 1'b1;
                        end else begin
                           ppos_in = ppos_ff + 2'd1;
                        end
                     end
                     PH_PIXELS: begin
                        if (depth8) begin
                           pix_out = 1'b1;
                           ctl.use_pal = 1'b1;
                        end else begin
                           acc_in = acc_shift;
                           if (bc_ff == 6'd2) begin
                              bc_in   = 6'd0;
                              pix_out = 1'b1;
                              pix_rgb = acc_shift[31:8];
                           end else begin
                              bc_in = bc_ff + 6'd1;
                           end
                        end
                     end
                     PH_PAD: begin
                        pad_in = pad_ff - 2'd1;
                        if (pad_ff == 2'd1) begin
                           phase_in = (row_ff >= height_ff) ? PH_DONE : PH_PIXELS;
                        end
                     end
                     default: begin
                        phase_in = PH_HALT;
                     end
                  endcase
               end
            end
         endcase

         if (start_pix) begin
            col_in   = 12'd0;
            row_in   = 13'd0;
            bc_in    = 6'd0;
            phase_in = (width_ff == 13'd0 || height_ff == 13'd0) ? PH_DONE : PH_PIXELS;
         end

         if (pix_out) begin
            ctl.valid     = 1'b1;
            res.kind      = KIND_PIXEL;
            res.pixel_x   = col_ff;
            res.pixel_y   = y_full[11:0];
            res.red       = pix_rgb[23:16];
            res.green     = pix_rgb[15:8];
            res.blue      = pix_rgb[7:0];
            if (col_next >= width_ff) begin
               col_in = 12'd0;
               row_in = row_next;
               if (pad_calc != 2'd0) begin
                  pad_in   = pad_calc;
                  phase_in = PH_PAD;
               end else begin
                  phase_in = (row_next >= height_ff) ? PH_DONE : PH_PIXELS;
               end
            end else begin
               col_in = col_next[11:0];
            end
         end

         if (err != ERR_NONE) begin
            phase_in       = PH_HALT;
            ctl.valid      = 1'b1;
            ctl.use_pal    = 1'b0;
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = err;
         end
      end
      res.image_width  = width_ff;
      res.image_height = height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         bc_ff      <= '0;
         acc_ff     <= '0;
         core_ff    <= 1'b0;
         width_ff   <= '0;
         height_ff  <= '0;
         depth_ff   <= '0;
         colours_ff <= '0;
         pidx_ff    <= '0;
         ppos_ff    <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         pad_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         bc_ff      <= bc_in;
         acc_ff     <= acc_in;
         core_ff    <= core_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         colours_ff <= colours_in;
         pidx_ff    <= pidx_in;
         ppos_ff    <= ppos_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         pad_ff     <= pad_in;
      end
   end

endmodule
